>>> src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define DGCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define DGCD_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> src/dgcd_pkg.sv
`timescale 1ns / 1ps
package dgcd_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_W    = 6;
  localparam int CNT_W     = 7;
  localparam int STK_W     = NODE_W + CNT_W;

  localparam logic KIND_EDGE  = 1'b0;
  localparam logic KIND_CHECK = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
  } in_item_t;

  typedef struct packed {
    logic cycle_found;
    logic edge_dropped;
  } result_t;

  typedef struct packed {
    logic                 rd_en;
    logic [NODE_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [NODE_W-1:0]    wr_addr;
    logic [MAX_NODES-1:0] wr_data;
    logic                 clear;
  } adj_req_t;

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    logic [STK_W-1:0]  wdata;
    logic              re;
    logic [NODE_W-1:0] raddr;
  } stk_req_t;

endpackage

>>> src/dgcd_ram.sv
`timescale 1ns / 1ps
module dgcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/dgcd_adj.sv
`timescale 1ns / 1ps
module dgcd_adj (
  input  logic                             clk,
  input  logic                             rst,
  input  dgcd_pkg::adj_req_t               req,
  output logic [dgcd_pkg::MAX_NODES-1:0]   rdata
);
  import dgcd_pkg::*;

  logic [MAX_NODES-1:0] row_valid;
  logic                 valid_q;
  logic [MAX_NODES-1:0] ram_q;

  dgcd_ram #(
    .WIDTH (MAX_NODES),
    .DEPTH (MAX_NODES)
  ) u_ram (
    .clk   (clk),
    .we    (req.wr_en),
    .waddr (req.wr_addr),
    .wdata (req.wr_data),
    .re    (req.rd_en),
    .raddr (req.rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      valid_q   <= 1'b0;
    end else begin
      if (req.clear) begin
        row_valid <= '0;
      end else if (req.wr_en) begin
        row_valid[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        valid_q <= row_valid[req.rd_addr];
      end
    end
  end

  // rows never written since the last clear read as empty
  assign rdata = valid_q ? ram_q : '0;

endmodule

>>> src/dgcd_seq.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dgcd_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  dgcd_pkg::in_item_t             item,
  output logic                           busy,
  output logic                           done,
  output dgcd_pkg::result_t              result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dgcd_pkg::CNT_W-1:0]     cfg_data,
  output dgcd_pkg::adj_req_t             adj_req,
  input  logic [dgcd_pkg::MAX_NODES-1:0] adj_rdata,
  output dgcd_pkg::stk_req_t             stk_req,
  input  logic [dgcd_pkg::STK_W-1:0]     stk_rdata
);
  import dgcd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_START,
    ST_LOAD,
    ST_SCAN,
    ST_POPW
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     node_count;
  logic [CNT_W-1:0]     n_eff;
  logic                 dropped;
  logic [NODE_W-1:0]    from_q;
  logic [NODE_W-1:0]    to_q;
  logic [MAX_NODES-1:0] visited;
  logic [MAX_NODES-1:0] on_path;
  logic [MAX_NODES-1:0] row;
  logic [CNT_W-1:0]     start_node;
  logic [CNT_W-1:0]     depth;
  logic [NODE_W-1:0]    cur_u;
  logic [CNT_W-1:0]     cur_j;
  logic [NODE_W-1:0]    j_idx;
  logic [NODE_W-1:0]    s_idx;
  logic [CNT_W-1:0]     depth_m1;
  logic [CNT_W-1:0]     depth_m2;
  logic                 accept;
  logic                 edge_drop;
  logic                 in_search;
  logic [CNT_W-1:0]     path_len;

  assign n_eff     = (node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count;
  assign busy      = (state != ST_IDLE);
  assign cfg_ready = ~busy && !start;
  assign accept    = start && !busy;
  assign edge_drop = (CNT_W'(item.from_node) >= n_eff) || (CNT_W'(item.to_node) >= n_eff);
  assign j_idx     = cur_j[NODE_W-1:0];
  assign s_idx     = start_node[NODE_W-1:0];
  assign depth_m1  = depth - CNT_W'(1);
  assign depth_m2  = depth - CNT_W'(2);
  assign in_search = (state == ST_LOAD) || (state == ST_SCAN) || (state == ST_POPW);
  assign path_len  = CNT_W'($countones(on_path));

  always_comb begin
    adj_req = '0;
    stk_req = '0;
    unique case (state)
      ST_IDLE: begin
        adj_req.rd_en   = accept && (item.kind == KIND_EDGE) && !edge_drop;
        adj_req.rd_addr = item.from_node;
      end
      ST_EDGE: begin
        adj_req.wr_en   = 1'b1;
        adj_req.wr_addr = from_q;
        adj_req.wr_data = adj_rdata | ({{(MAX_NODES-1){1'b0}}, 1'b1} << to_q);
      end
      ST_START: begin
        adj_req.rd_en   = (start_node != n_eff) && !visited[s_idx];
        adj_req.rd_addr = s_idx;
        adj_req.clear   = (start_node == n_eff);
      end
      ST_LOAD: begin
      end
      ST_SCAN: begin
        if (cur_j >= n_eff) begin
          stk_req.re    = (depth != CNT_W'(1));
          stk_req.raddr = depth_m2[NODE_W-1:0];
        end else if (row[j_idx]) begin
          adj_req.clear   = on_path[j_idx];
          adj_req.rd_en   = !on_path[j_idx] && !visited[j_idx];
          adj_req.rd_addr = j_idx;
          stk_req.we      = !on_path[j_idx] && !visited[j_idx];
          stk_req.waddr   = depth_m1[NODE_W-1:0];
          stk_req.wdata   = {cur_u, cur_j + CNT_W'(1)};
        end
      end
      ST_POPW: begin
        adj_req.rd_en   = 1'b1;
        adj_req.rd_addr = stk_rdata[STK_W-1 -: NODE_W];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      node_count <= CNT_W'(MAX_NODES);
      dropped    <= 1'b0;
      done       <= 1'b0;
      visited    <= '0;
      on_path    <= '0;
      depth      <= '0;
      start_node <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        node_count <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (item.kind == KIND_EDGE) begin
              from_q <= item.from_node;
              to_q   <= item.to_node;
              if (edge_drop) begin
                dropped <= 1'b1;
              end else begin
                state <= ST_EDGE;
              end
            end else begin
              visited    <= '0;
              on_path    <= '0;
              depth      <= '0;
              start_node <= '0;
              state      <= ST_START;
            end
          end
        end
        ST_EDGE: begin
          state <= ST_IDLE;
        end
        ST_START: begin
          if (start_node == n_eff) begin
            done                <= 1'b1;
            result.cycle_found  <= 1'b0;
            result.edge_dropped <= dropped;
            dropped             <= 1'b0;
            state               <= ST_IDLE;
          end else if (visited[s_idx]) begin
            start_node <= start_node + CNT_W'(1);
          end else begin
            visited[s_idx] <= 1'b1;
            on_path[s_idx] <= 1'b1;
            cur_u          <= s_idx;
            cur_j          <= '0;
            depth          <= CNT_W'(1);
            state          <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          row   <= adj_rdata;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (cur_j >= n_eff) begin
            on_path[cur_u] <= 1'b0;
            depth          <= depth_m1;
            if (depth == CNT_W'(1)) begin
              start_node <= start_node + CNT_W'(1);
              state      <= ST_START;
            end else begin
              state <= ST_POPW;
            end
          end else if (!row[j_idx]) begin
            cur_j <= cur_j + CNT_W'(1);
          end else if (on_path[j_idx]) begin
            done                <= 1'b1;
            result.cycle_found  <= 1'b1;
            result.edge_dropped <= dropped;
            dropped             <= 1'b0;
            depth               <= '0;
            state               <= ST_IDLE;
          end else if (visited[j_idx]) begin
            cur_j <= cur_j + CNT_W'(1);
          end else begin
            visited[j_idx] <= 1'b1;
            on_path[j_idx] <= 1'b1;
            cur_u          <= j_idx;
            cur_j          <= '0;
            depth          <= depth + CNT_W'(1);
            state          <= ST_LOAD;
          end
        end
        ST_POPW: begin
          cur_u <= stk_rdata[STK_W-1 -: NODE_W];
          cur_j <= stk_rdata[CNT_W-1:0];
          state <= ST_LOAD;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `DGCD_ASSERT(a_done_idle, done |-> (state == ST_IDLE), "result strobe outside idle")
  `DGCD_ASSERT(a_depth_bound, depth <= n_eff, "path deeper than node count")
  `DGCD_ASSERT(a_path_count, in_search |-> (path_len == depth), "path marks disagree with depth")
  `DGCD_NEVER(a_cfg_busy, cfg_valid && cfg_ready && busy, "config transfer during search")

endmodule

>>> src/directed_graph_cycle_detect.sv
`timescale 1ns / 1ps
// Directed graph cycle detector.
// Items arrive on start/item and transfer at a rising edge with start high and
// busy low. kind 0 adds the edge from_node -> to_node; kind 1 runs the check.
// An edge item with a node at or above node_count sets the dropped flag while
// busy stays low. A stored edge does a read-modify-write
// of its adjacency row: busy is high in the cycle after the transfer.
// A check item runs a depth-first search with one shared scan step per cycle,
// while no adjacency row is being loaded, over the adjacency row of the node
// on top of the path stack.
// The result appears on result with done high for exactly one cycle, at the end
// of the search or as soon as a back edge is seen; the receiver cannot stall.
// The graph and the dropped flag then clear in the same cycle (row valid flags).
// The node_count register is written on cfg_valid/cfg_ready; cfg_ready is high
// while the block is idle and start is low. Reset (rst, synchronous) empties the
// graph, clears the dropped flag and sets node_count to 64; no clearing pass.
module directed_graph_cycle_detect (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  dgcd_pkg::in_item_t         item,
  output logic                       busy,
  output logic                       done,
  output dgcd_pkg::result_t          result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [dgcd_pkg::CNT_W-1:0] cfg_data
);
  import dgcd_pkg::*;

  adj_req_t             adj_req;
  logic [MAX_NODES-1:0] adj_rdata;
  stk_req_t             stk_req;
  logic [STK_W-1:0]     stk_rdata;

  dgcd_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .adj_req   (adj_req),
    .adj_rdata (adj_rdata),
    .stk_req   (stk_req),
    .stk_rdata (stk_rdata)
  );

  dgcd_adj u_adj (
    .clk   (clk),
    .rst   (rst),
    .req   (adj_req),
    .rdata (adj_rdata)
  );

  dgcd_ram #(
    .WIDTH (STK_W),
    .DEPTH (MAX_NODES)
  ) u_stack (
    .clk   (clk),
    .we    (stk_req.we),
    .waddr (stk_req.waddr),
    .wdata (stk_req.wdata),
    .re    (stk_req.re),
    .raddr (stk_req.raddr),
    .rdata (stk_rdata)
  );

endmodule
